// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the string hash block.
// No dependencies; expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ish_pkg.sv -----
// Package of the string hash block: widths, reset values and the command struct.
// Used by the controller, the datapath and the top level.
package ish_pkg;

    localparam int CodeW   = 21;
    localparam int AccW    = 32;
    localparam int ShW     = 4;
    localparam int SizeW   = 31;
    localparam int CntW    = 5;

    localparam logic [ShW-1:0]   ShiftInit    = 4'd5;
    localparam logic [AccW-1:0]  HashBias     = 32'h0000_0061;
    localparam logic [SizeW-1:0] SizeReset    = 31'd256;
    localparam logic [CodeW-1:0] UpperA       = 21'h41;
    localparam logic [CodeW-1:0] UpperZ       = 21'h5A;
    localparam logic [CodeW-1:0] CaseOffset   = 21'h20;

    // Register indexes of the configuration port.
    localparam logic CfgTableSize = 1'b0;
    localparam logic CfgCaseFold  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;      // hash the accepted character
        logic start;     // latch the folded hash, restart the string
        logic div_step;  // one restoring division step
        logic load;      // move the remainder into the output register
    } t_ish_cmd;

endpackage

// ----- design/ish_datapath.sv -----
// Datapath of the string hash block: configuration, hash state, serial divider
// and output register. Depends on ish_pkg.
module ish_datapath import ish_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ish_cmd         i_cmd,
    input  logic [CodeW-1:0] i_char_code,
    input  logic             i_char_valid,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [SizeW-1:0] i_cfg_data,
    output logic [SizeW-1:0] o_bucket_index
);

    logic [SizeW-1:0] r_table_size;
    logic             r_case_fold;
    logic [AccW-1:0]  r_acc, n_acc;
    logic [ShW-1:0]   r_shift, n_shift;
    logic [AccW-1:0]  r_dvd;
    logic [AccW-1:0]  r_rem;
    logic [SizeW-1:0] r_bucket;

    logic [CodeW-1:0] folded;
    logic [AccW-1:0]  diff;
    logic [AccW-1:0]  trial;
    logic [AccW-1:0]  divisor;

    always_comb begin
        folded = i_char_code;
        if (r_case_fold && i_char_code >= UpperA && i_char_code <= UpperZ) begin
            folded = i_char_code + CaseOffset;
        end
        diff    = {{(AccW-CodeW){1'b0}}, folded} - HashBias;
        n_acc   = r_acc;
        n_shift = r_shift;
        if (i_cmd.step && i_char_valid) begin
            n_acc   = r_acc ^ (diff << r_shift);
            n_shift = r_shift ^ diff[ShW-1:0];
        end
        divisor = {1'b0, r_table_size};
        trial   = {r_rem[AccW-2:0], r_dvd[AccW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SizeReset;
            r_case_fold  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgTableSize: r_table_size <= i_cfg_data;
                CfgCaseFold:  r_case_fold  <= i_cfg_data[0];
                default:      r_case_fold  <= r_case_fold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_shift <= ShiftInit;
        end else if (i_cmd.start) begin
            r_acc   <= '0;
            r_shift <= ShiftInit;
        end else begin
            r_acc   <= n_acc;
            r_shift <= n_shift;
        end
    end

    // Restoring divider, one quotient bit a cycle; only the remainder is kept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dvd <= n_acc ^ (n_acc >> 16);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= (trial >= divisor) ? trial - divisor : trial;
        end
        if (i_cmd.load) begin
            r_bucket <= (r_table_size == '0) ? '0 : r_rem[SizeW-1:0];
        end
    end

    assign o_bucket_index = r_bucket;

endmodule

// ----- design/ish_ctrl.sv -----
// Controller of the string hash block: sequences hashing, division and output.
// Depends on ish_pkg.
module ish_ctrl import ish_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_last,
    input  logic     i_stall,
    output logic     o_stall,
    output logic     o_valid,
    output t_ish_cmd o_cmd
);

    localparam logic [1:0] StAccum = 2'd0;
    localparam logic [1:0] StDiv   = 2'd1;
    localparam logic [1:0] StDone  = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [CntW-1:0] r_cnt;
    logic            r_out_valid;
    logic            accept;
    logic            out_free;

    assign accept   = i_valid && (r_state == StAccum);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.step     = accept;
        o_cmd.start    = accept && i_last;
        unique case (r_state)
            StAccum: if (accept && i_last) begin
                n_state = StDiv;
            end
            StDiv: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '1) begin
                    n_state = StDone;
                end
            end
            StDone: if (out_free) begin
                o_cmd.load = 1'b1;
                n_state    = StAccum;
            end
            default: n_state = StAccum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StAccum;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == StDiv) ? r_cnt + 1'b1 : '0;
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != StAccum);
    assign o_valid = r_out_valid;

endmodule

// ----- design/identifier_string_hash_core.sv -----
// Top level of the identifier string hash block.
// Depends on ish_pkg, ish_ctrl and ish_datapath.
//
// Characters of a string arrive as words on the input channel (i_valid,
// o_stall), one code point per word with a char_valid flag and a last mark.
// While a string is being hashed one word is taken every cycle. A word with
// char_valid clear and last clear changes nothing; with last set it ends the
// string without adding a character, so an empty string gives bucket 0.
// When a word with last set is accepted, the folded hash goes to a serial
// restoring divider, one bit per cycle: the input is stalled through the 32
// division steps and the output load, and the bucket index appears on the
// output channel (o_valid, i_stall) with that load, which waits until the
// output register is free. The output register parts the two sides: hashing
// of the next string goes on while a finished bucket waits for the receiver.
// If the receiver still stalls when the next division completes, the block
// holds in its done state and keeps the input stalled until the older bucket
// has been taken. Configuration (table size, case folding) is to be written
// by the user through the plain write port only while the block is idle;
// the block leaves this unenforced. Synchronous reset sets the table size
// to 256, clears case folding, empties the output and restarts the hash.
module identifier_string_hash_core import ish_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CodeW-1:0] i_char_code,
    input  logic             i_char_valid,
    input  logic             i_last,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [SizeW-1:0] o_bucket_index,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [SizeW-1:0] i_cfg_data
);

    t_ish_cmd cmd;

    // The controller owns the handshakes and the division count.
    ish_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // The datapath holds the hash state, the divider and the result word.
    ish_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_char_code    (i_char_code),
        .i_char_valid   (i_char_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_bucket_index (o_bucket_index)
    );

endmodule

// ----- design/ish_checker.sv -----
// Port-level checker of the string hash block, bound to the top level.
// Depends on ish_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ish_checker import ish_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_last,
    input logic             o_valid,
    input logic             i_stall,
    input logic [SizeW-1:0] o_bucket_index
);

    // A stalled result word stays and keeps its value.
    `ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_bucket_index))
    // Reset empties the output register.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid)
    // Ending a string starts the divider, which holds off further input.
    `ASSERT_NEXT(a_last_stalls, i_valid && !o_stall && i_last, o_stall)
    // A new result only appears while the input is still held off.
    `ASSERT_SAME(a_result_in_div, $rose(o_valid), $past(o_stall))

endmodule

bind identifier_string_hash_core ish_checker u_ish_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_bucket_index (o_bucket_index)
);
